// ===== hdl/tiny_register_machine_step_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tiny register machine
// Shared helpers for concurrent checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TINY_REGISTER_MACHINE_STEP_MACROS_SVH
`define TINY_REGISTER_MACHINE_STEP_MACROS_SVH

// same-cycle implication
`define TRM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/trm_pkg.sv =====
// ----------------------------------------------------------------------------
// trm_pkg
// Types and codes shared by the tiny register machine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package trm_pkg;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   typedef enum logic [3:0] {
      OP_MOV = 4'd1,
      OP_MOC = 4'd2,
      OP_ADD = 4'd3,
      OP_ADC = 4'd4,
      OP_SUB = 4'd5,
      OP_SUC = 4'd6,
      OP_JMP = 4'd7,
      OP_PTN = 4'd8,
      OP_PTC = 4'd9
   } op_type;

   typedef enum logic [2:0] {
      KIND_SILENT = 3'd0,
      KIND_NUMBER = 3'd1,
      KIND_CHAR   = 3'd2,
      KIND_HALT   = 3'd3,
      KIND_ERROR  = 3'd4
   } kind_type;

   // one stored program line
   typedef struct packed {
      logic [3:0]  opcode;
      logic [3:0]  first_operand;
      logic [15:0] second_operand;
   } prog_line_type;

   // execute decision handed back to the control path
   typedef struct packed {
      kind_type kind;
      logic     reg_we;
      logic     set_stop;
   } exec_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/trm_channels.sv =====
// ----------------------------------------------------------------------------
// trm_channels
// Valid/ready channel interfaces for request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface trm_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic [3:0]         opcode;
   logic [3:0]         first_operand;
   logic signed [15:0] second_operand;

   modport source (output valid, func, opcode, first_operand, second_operand,
                   input ready);
   modport sink (input valid, func, opcode, first_operand, second_operand,
                 output ready);
endinterface

interface trm_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic signed [31:0] value;
   logic [8:0]         line_index;

   modport source (output valid, kind, value, line_index, input ready);
   modport sink (input valid, kind, value, line_index, output ready);
endinterface

`default_nettype wire

// ===== hdl/trm_prog_store.sv =====
// ----------------------------------------------------------------------------
// trm_prog_store
// Single-port-write, single-port-read program memory, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module trm_prog_store
   import trm_pkg::*;
#(
   parameter int PROGRAM_DEPTH = 256
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(PROGRAM_DEPTH)-1:0] wr_addr,
   input  wire prog_line_type                    wr_line,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(PROGRAM_DEPTH)-1:0] rd_addr,
   output prog_line_type                         rd_line
);

   prog_line_type mem [PROGRAM_DEPTH];
   prog_line_type rd_line_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_line;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_line_ff <= mem[rd_addr];
      end
   end

   assign rd_line = rd_line_ff;

endmodule

`default_nettype wire

// ===== hdl/trm_regfile.sv =====
// ----------------------------------------------------------------------------
// trm_regfile
// Register file: two registered reads, one write, per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module trm_regfile
   import trm_pkg::*;
#(
   parameter int REGISTER_COUNT = 13,
   parameter int DATA_WIDTH     = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              clear,
   input  wire logic                              rd_en,
   input  wire logic [$clog2(REGISTER_COUNT)-1:0] rd_idx_a,
   input  wire logic [$clog2(REGISTER_COUNT)-1:0] rd_idx_b,
   input  wire logic                              wr_en,
   input  wire logic [$clog2(REGISTER_COUNT)-1:0] wr_idx,
   input  wire logic [DATA_WIDTH-1:0]             wr_data,
   output logic [DATA_WIDTH-1:0]                  rd_data_a,
   output logic [DATA_WIDTH-1:0]                  rd_data_b
);

   logic [DATA_WIDTH-1:0]     mem [REGISTER_COUNT];
   logic [REGISTER_COUNT-1:0] valid_ff;
   logic [REGISTER_COUNT-1:0] valid_in;
   logic [DATA_WIDTH-1:0]     rd_a_ff;
   logic [DATA_WIDTH-1:0]     rd_b_ff;
   logic                      rd_a_valid_ff;
   logic                      rd_b_valid_ff;

   // an entry not written since the last clear reads as zero
   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff       <= mem[rd_idx_a];
         rd_b_ff       <= mem[rd_idx_b];
         rd_a_valid_ff <= valid_ff[rd_idx_a];
         rd_b_valid_ff <= valid_ff[rd_idx_b];
      end
   end

   assign rd_data_a = rd_a_valid_ff ? rd_a_ff : '0;
   assign rd_data_b = rd_b_valid_ff ? rd_b_ff : '0;

endmodule

`default_nettype wire

// ===== hdl/trm_exec.sv =====
// ----------------------------------------------------------------------------
// trm_exec
// Instruction decode, checks, ALU and next program counter.
// ----------------------------------------------------------------------------
`default_nettype none

module trm_exec
   import trm_pkg::*;
#(
   parameter int REGISTER_COUNT = 13,
   parameter int DATA_WIDTH     = 32,
   parameter int PC_W           = 9
) (
   input  wire prog_line_type         line,
   input  wire logic [DATA_WIDTH-1:0] reg_a,
   input  wire logic [DATA_WIDTH-1:0] reg_b,
   input  wire logic [PC_W-1:0]       pc,
   input  wire logic [PC_W-1:0]       prog_len,
   input  wire logic                  stopped,
   output exec_ctl_type               ctl,
   output logic [DATA_WIDTH-1:0]      wr_data,
   output logic [PC_W-1:0]            pc_next,
   output logic [31:0]                value
);

   localparam int TGT_W = PC_W + 17;

   logic                    halt;
   logic                    bad_op;
   logic                    bad_ra;
   logic                    bad_rb;
   logic                    reg_src;
   logic                    err;
   logic                    jmp_taken;
   logic                    jmp_err;
   logic [TGT_W-1:0]        target;
   logic [DATA_WIDTH+15:0]  imm_ext;
   logic [DATA_WIDTH-1:0]   imm;
   logic [DATA_WIDTH+31:0]  a_ext;
   logic [PC_W-1:0]         pc_inc;

   assign halt    = stopped || (pc >= prog_len);
   assign bad_ra  = {1'b0, line.first_operand} >= 5'(REGISTER_COUNT);
   assign bad_rb  = line.second_operand >= 16'(REGISTER_COUNT);
   assign imm_ext = {{DATA_WIDTH{line.second_operand[15]}}, line.second_operand};
   assign imm     = imm_ext[DATA_WIDTH-1:0];
   assign a_ext   = {32'b0, reg_a};
   assign pc_inc  = pc + PC_W'(1);

   // relative target, two's complement over a widened range
   assign target = {17'b0, pc}
                 + {{(PC_W + 1){line.second_operand[15]}}, line.second_operand};
   assign jmp_taken = !reg_a[DATA_WIDTH-1];

   always_comb begin
      bad_op  = 1'b0;
      reg_src = 1'b0;
      unique case (line.opcode) inside
         OP_MOV, OP_ADD, OP_SUB: reg_src = 1'b1;
         OP_MOC, OP_ADC, OP_SUC, OP_JMP, OP_PTN, OP_PTC: reg_src = 1'b0;
         default: bad_op = 1'b1;
      endcase
   end

   assign err     = bad_op || bad_ra || (reg_src && bad_rb);
   assign jmp_err = (line.opcode == OP_JMP) && jmp_taken
                 && (target[TGT_W-1] || (target > {17'b0, prog_len}));

   always_comb begin
      wr_data = reg_a;
      unique case (line.opcode) inside
         OP_MOV:  wr_data = reg_b;
         OP_MOC:  wr_data = imm;
         OP_ADD:  wr_data = reg_a + reg_b;
         OP_ADC:  wr_data = reg_a + imm;
         OP_SUB:  wr_data = reg_a - reg_b;
         OP_SUC:  wr_data = reg_a - imm;
         default: wr_data = reg_a;
      endcase
   end

   always_comb begin
      ctl.kind     = KIND_SILENT;
      ctl.reg_we   = 1'b0;
      ctl.set_stop = 1'b0;
      pc_next      = pc;
      value        = '0;
      if (halt) begin
         ctl.kind     = KIND_HALT;
         ctl.set_stop = 1'b1;
      end else if (err || jmp_err) begin
         ctl.kind     = KIND_ERROR;
         ctl.set_stop = 1'b1;
      end else begin
         pc_next = pc_inc;
         unique case (line.opcode) inside
            OP_MOV, OP_MOC, OP_ADD, OP_ADC, OP_SUB, OP_SUC: ctl.reg_we = 1'b1;
            OP_JMP: begin
               if (jmp_taken) begin
                  pc_next = target[PC_W-1:0];
               end
            end
            OP_PTN: begin
               ctl.kind = KIND_NUMBER;
               value    = a_ext[31:0];
            end
            default: begin
               ctl.kind = KIND_CHAR;
               value    = {24'b0, reg_a[7:0]};
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tiny_register_machine_step.sv =====
// ----------------------------------------------------------------------------
// tiny_register_machine_step
// Register machine top level: load and step words in, step results out.
// ----------------------------------------------------------------------------
// A load word writes the program store at once while it has room and gives
// no response. A step word passes a fetch read of the program store at the
// program counter, an operand read of both registers from the register
// file, and an execute stage that writes the register file and the program
// counter back; the result lands in an output register. A new word is taken
// once the step ahead is executing without a stall, and a load word every
// cycle while no step holds the input; the two memory reads in series limit
// the step rate. The next fetch address is forwarded from the execute stage.
// A result left waiting holds back further words only once a second step
// result is ready behind it.
`default_nettype none

`include "tiny_register_machine_step_macros.svh"

module tiny_register_machine_step
   import trm_pkg::*;
#(
   parameter int PROGRAM_DEPTH  = 256,
   parameter int REGISTER_COUNT = 13,
   parameter int DATA_WIDTH     = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   trm_req_if.sink    req_chan,
   trm_rsp_if.source  rsp_chan
);

   localparam int PC_W   = $clog2(PROGRAM_DEPTH + 1);
   localparam int ADDR_W = $clog2(PROGRAM_DEPTH);
   localparam int IDX_W  = $clog2(REGISTER_COUNT);

   logic                  req_ready;
   logic                  accept;
   logic                  load_acc;
   logic                  step_acc;
   logic                  first_load;
   logic                  store_we;
   logic                  s2_fire;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic                  s2_valid_ff;
   logic                  s2_valid_in;
   logic [PC_W-1:0]       pc_ff;
   logic [PC_W-1:0]       pc_in;
   logic [PC_W-1:0]       len_ff;
   logic [PC_W-1:0]       len_in;
   logic                  stopped_ff;
   logic                  stopped_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   kind_type              rsp_kind_ff;
   logic [31:0]           rsp_value_ff;
   logic [8:0]            rsp_line_ff;

   prog_line_type         wr_line;
   prog_line_type         cur_line;
   logic [PC_W-1:0]       fetch_pc;
   logic [IDX_W-1:0]      idx_a;
   logic [IDX_W-1:0]      idx_b;
   logic [DATA_WIDTH-1:0] reg_a;
   logic [DATA_WIDTH-1:0] reg_b;
   exec_ctl_type          ctl;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [PC_W-1:0]       pc_next;
   logic [31:0]           value;
   logic [PC_W+8:0]       pc_next_ext;

   // handshake
   assign s2_fire   = s2_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_ready = !s1_valid_ff && (!s2_valid_ff || s2_fire);
   assign accept    = req_chan.valid && req_ready;
   assign load_acc  = accept && (req_chan.func == FUNC_LOAD);
   assign step_acc  = accept && (req_chan.func == FUNC_STEP);
   assign req_chan.ready = req_ready;

   assign first_load = load_acc && (len_ff == '0);
   assign store_we   = load_acc && (len_ff < PC_W'(PROGRAM_DEPTH));

   assign wr_line.opcode         = req_chan.opcode;
   assign wr_line.first_operand  = req_chan.first_operand;
   assign wr_line.second_operand = req_chan.second_operand;

   // fetch address forwarded from the step under execution
   assign fetch_pc = s2_valid_ff ? pc_next : pc_ff;

   trm_prog_store #(
      .PROGRAM_DEPTH (PROGRAM_DEPTH)
   ) u_prog (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_line (wr_line),
      .rd_en   (step_acc),
      .rd_addr (fetch_pc[ADDR_W-1:0]),
      .rd_line (cur_line)
   );

   // out-of-range indices go to entry zero; a bad register operand is an error
   assign idx_a = ({1'b0, cur_line.first_operand} < 5'(REGISTER_COUNT))
                ? cur_line.first_operand[IDX_W-1:0] : '0;
   assign idx_b = (cur_line.second_operand < 16'(REGISTER_COUNT))
                ? cur_line.second_operand[IDX_W-1:0] : '0;

   trm_regfile #(
      .REGISTER_COUNT (REGISTER_COUNT),
      .DATA_WIDTH     (DATA_WIDTH)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .clear     (first_load),
      .rd_en     (s1_valid_ff),
      .rd_idx_a  (idx_a),
      .rd_idx_b  (idx_b),
      .wr_en     (s2_fire && ctl.reg_we),
      .wr_idx    (idx_a),
      .wr_data   (wr_data),
      .rd_data_a (reg_a),
      .rd_data_b (reg_b)
   );

   trm_exec #(
      .REGISTER_COUNT (REGISTER_COUNT),
      .DATA_WIDTH     (DATA_WIDTH),
      .PC_W           (PC_W)
   ) u_exec (
      .line     (cur_line),
      .reg_a    (reg_a),
      .reg_b    (reg_b),
      .pc       (pc_ff),
      .prog_len (len_ff),
      .stopped  (stopped_ff),
      .ctl      (ctl),
      .wr_data  (wr_data),
      .pc_next  (pc_next),
      .value    (value)
   );

   // control next state; a first load after a step overrides its effects
   always_comb begin
      s1_valid_in = step_acc;
      s2_valid_in = s1_valid_ff || (s2_valid_ff && !s2_fire);
      len_in      = store_we ? len_ff + PC_W'(1) : len_ff;
      pc_in       = pc_ff;
      stopped_in  = stopped_ff;
      if (s2_fire) begin
         pc_in      = pc_next;
         stopped_in = stopped_ff || ctl.set_stop;
      end
      if (first_load) begin
         pc_in      = '0;
         stopped_in = 1'b0;
      end
      rsp_valid_in = s2_fire || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         pc_ff        <= '0;
         len_ff       <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         pc_ff        <= pc_in;
         len_ff       <= len_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign pc_next_ext = {9'b0, pc_next};

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         rsp_kind_ff  <= ctl.kind;
         rsp_value_ff <= value;
         rsp_line_ff  <= pc_next_ext[8:0];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_kind_ff;
   assign rsp_chan.value      = rsp_value_ff;
   assign rsp_chan.line_index = rsp_line_ff;

   // checks
   `TRM_ASSERT_NEXT(a_fetch_moves_on, clock, reset, s1_valid_ff, !s1_valid_ff && s2_valid_ff, "fetch stage did not advance")
   `TRM_ASSERT_NOW(a_pc_in_program, clock, reset, 1'b1, pc_ff <= len_ff, "program counter beyond program")
   `TRM_ASSERT_NOW(a_write_is_silent, clock, reset, s2_fire && ctl.reg_we, ctl.kind == KIND_SILENT && !ctl.set_stop, "register write on a reporting step")

endmodule

`default_nettype wire
